@@ rtl/aprlm_pkg.sv @@
// Shared types and constants for the peak and RMS audio level meter.
// Holds the transfer payload structs, operation codes and sequencer states.
// Has no dependencies of its own.
package aprlm_pkg;

    localparam int SAMPLE_BITS   = 24;
    localparam int MAG_BITS      = 24;
    localparam int COUNT_BITS    = 24;
    localparam int DB_BITS       = 12;
    localparam int SUM_BITS      = 64;
    localparam int TICK_BITS     = 32;
    localparam int WORD_BITS     = 32;
    localparam int LOG_FRAC_BITS = 24;
    localparam int LEVEL_BITS    = 5 + LOG_FRAC_BITS;
    localparam int CNT_BITS      = 6;

    localparam logic [CNT_BITS-1:0] MUL_LAST  = CNT_BITS'(WORD_BITS - 1);
    localparam logic [CNT_BITS-1:0] DIV_LAST  = CNT_BITS'(SUM_BITS - 1);
    localparam logic [CNT_BITS-1:0] SQRT_LAST = CNT_BITS'(SUM_BITS / 2 - 1);
    localparam logic [4:0]          LOG_LAST  = 5'(LOG_FRAC_BITS - 1);

    localparam logic [TICK_BITS-1:0]  INTERVAL_RESET = TICK_BITS'(5000);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX      = '1;
    localparam logic [WORD_BITS-1:0]  DB_SCALE_K     = WORD_BITS'(1010089052);
    localparam logic [WORD_BITS-1:0]  FULL_SCALE     = WORD_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [16:0]           DB_FLOOR_MAG   = 17'd2048;
    localparam logic [DB_BITS-1:0]    SILENT_DB      = DB_BITS'(2048);

    localparam logic [1:0] OP_SAMPLE    = 2'd0;
    localparam logic [1:0] OP_FRAME_END = 2'd1;
    localparam logic [1:0] OP_TICK      = 2'd2;

    typedef struct packed {
        logic [1:0]                    operation;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          sample_invalid;
    } meter_in_t;

    typedef struct packed {
        logic [MAG_BITS-1:0]       peak_magnitude;
        logic [MAG_BITS-1:0]       rms_magnitude;
        logic signed [DB_BITS-1:0] peak_dbfs_tenths;
        logic signed [DB_BITS-1:0] rms_dbfs_tenths;
        logic                      peak_silent;
        logic                      rms_silent;
        logic [COUNT_BITS-1:0]     counted_samples;
    } meter_out_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_MUL,
        S_SQ_ACC,
        S_DIV,
        S_SQRT,
        S_CLAMP,
        S_LVL_START,
        S_NORM,
        S_LOG_MUL,
        S_LOG_STEP,
        S_DB_PREP,
        S_DB_MUL,
        S_DB_DONE,
        S_LVL_END,
        S_OUT
    } meter_state_t;

endpackage

@@ rtl/audio_peak_rms_level_meter_unit.sv @@
// Top level of the peak and RMS audio level meter with dBFS reporting.
// Uses aprlm_pkg for payload types, constants and sequencer states.
// Contains the accumulators, a bit-serial multiplier and the report sequencer.
//
//   Channel   Signals                              Direction  Carries
//   in        in_valid, in_ready, in_data          to block   sample, frame end or tick
//   out       out_valid, out_ready, out_data       from block one level report
//   cfg       cfg_wr_en, cfg_wr_data               to block   interval_ticks
//
// A tick, an invalid sample or a non-reporting frame end is taken in without leaving the idle state.
// A valid sample is squared on the shift-and-add multiplier and then added to the square sum.
// A reporting frame end runs 64 divide steps and 32 root steps when samples were counted,
// and a logarithm of 24 serial squarings on the same multiplier for each nonzero level.
// Reset restores interval_ticks to 5000 and clears all accumulators.
// A stalled output holds its report while the next items are taken in.
module audio_peak_rms_level_meter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  aprlm_pkg::meter_in_t                in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output aprlm_pkg::meter_out_t               out_data,
    input  logic                                cfg_wr_en,
    input  logic [aprlm_pkg::TICK_BITS-1:0]     cfg_wr_data
);

    localparam int SB = aprlm_pkg::SAMPLE_BITS;
    localparam int WB = aprlm_pkg::WORD_BITS;
    localparam int LB = aprlm_pkg::LEVEL_BITS;

    aprlm_pkg::meter_state_t state_reg, state_next;

    logic [aprlm_pkg::TICK_BITS-1:0]  interval_reg, interval_next;
    logic [SB-1:0]                    peak_hold_reg, peak_hold_next;
    logic [aprlm_pkg::SUM_BITS-1:0]   square_sum_reg, square_sum_next;
    logic [aprlm_pkg::COUNT_BITS-1:0] valid_count_reg, valid_count_next;
    logic [aprlm_pkg::TICK_BITS-1:0]  elapsed_reg, elapsed_next;
    logic                             out_valid_reg, out_valid_next;
    aprlm_pkg::meter_out_t            out_data_reg, out_data_next;
    aprlm_pkg::meter_out_t            res_reg, res_next;

    logic [WB-1:0]                    mul_a_reg, mul_a_next;
    logic [2*WB-1:0]                  mul_p_reg, mul_p_next;
    logic [aprlm_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [aprlm_pkg::SUM_BITS-1:0]   work_reg, work_next;
    logic [33:0]                      rem_reg, rem_next;
    logic [WB-1:0]                    root_reg, root_next;
    logic [SB-1:0]                    rms_reg, rms_next;
    logic [4:0]                       n_reg, n_next;
    logic [aprlm_pkg::LOG_FRAC_BITS-1:0] frac_reg, frac_next;
    logic [4:0]                       step_reg, step_next;
    logic                             sel_reg, sel_next;
    logic [aprlm_pkg::DB_BITS-1:0]    db_reg, db_next;

    logic                             in_fire;
    logic [SB-1:0]                    smp_raw;
    logic [SB-1:0]                    smp_mag;
    logic [WB:0]                      mul_sum;
    logic [2*WB-1:0]                  mul_step;
    logic [aprlm_pkg::SUM_BITS:0]     sum_add;
    logic [24:0]                      div_sh;
    logic [24:0]                      div_diff;
    logic                             div_ge;
    logic [33:0]                      sq_rem;
    logic [33:0]                      sq_trial;
    logic [33:0]                      sq_diff;
    logic                             sq_ge;
    logic [SB-1:0]                    rms_clamp;
    logic [SB-1:0]                    lvl_a;
    logic [WB-1:0]                    log_y;
    logic [WB-1:0]                    log_y_adj;
    logic [LB-1:0]                    m_base;
    logic [LB-1:0]                    m_val;
    logic [17:0]                      db_round;
    logic [16:0]                      db_mag;
    logic [aprlm_pkg::DB_BITS-1:0]    db_neg;

    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign smp_raw = in_data.sample;
    assign smp_mag = smp_raw[SB-1] ? ((~smp_raw) + SB'(1)) : smp_raw;

    assign mul_sum  = {1'b0, mul_p_reg[2*WB-1:WB]} + (mul_p_reg[0] ? {1'b0, mul_a_reg} : '0);
    assign mul_step = {mul_sum, mul_p_reg[WB-1:1]};

    assign sum_add = {1'b0, square_sum_reg} + {1'b0, mul_p_reg};

    assign div_sh   = {rem_reg[23:0], work_reg[aprlm_pkg::SUM_BITS-1]};
    assign div_ge   = div_sh >= {1'b0, valid_count_reg};
    assign div_diff = div_sh - {1'b0, valid_count_reg};

    assign sq_rem   = {rem_reg[31:0], work_reg[aprlm_pkg::SUM_BITS-1 -: 2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge    = sq_rem >= sq_trial;
    assign sq_diff  = sq_rem - sq_trial;

    assign rms_clamp = (root_reg > aprlm_pkg::FULL_SCALE) ? SB'(aprlm_pkg::FULL_SCALE)
                                                          : root_reg[SB-1:0];
    assign lvl_a     = sel_reg ? rms_reg : peak_hold_reg;

    assign log_y     = mul_p_reg[61:30];
    assign log_y_adj = log_y[WB-1] ? {1'b0, log_y[WB-1:1]} : log_y;

    assign m_base   = {5'(SB - 1) - n_reg, {aprlm_pkg::LOG_FRAC_BITS{1'b0}}};
    assign m_val    = m_base - LB'(frac_reg);
    assign db_round = {1'b0, mul_p_reg[63:47]} + 18'd1;
    assign db_mag   = db_round[17:1];
    assign db_neg   = (db_mag > aprlm_pkg::DB_FLOOR_MAG) ? aprlm_pkg::SILENT_DB
                                                         : aprlm_pkg::DB_BITS'(17'd0 - db_mag);

    always_comb
    begin
        state_next       = state_reg;
        interval_next    = interval_reg;
        peak_hold_next   = peak_hold_reg;
        square_sum_next  = square_sum_reg;
        valid_count_next = valid_count_reg;
        elapsed_next     = elapsed_reg;
        out_valid_next   = out_valid_reg;
        out_data_next    = out_data_reg;
        res_next         = res_reg;
        mul_a_next       = mul_a_reg;
        mul_p_next       = mul_p_reg;
        cnt_next         = cnt_reg;
        work_next        = work_reg;
        rem_next         = rem_reg;
        root_next        = root_reg;
        rms_next         = rms_reg;
        n_next           = n_reg;
        frac_next        = frac_reg;
        step_next        = step_reg;
        sel_next         = sel_reg;
        db_next          = db_reg;
        in_ready         = (state_reg == aprlm_pkg::S_IDLE);

        if (cfg_wr_en)
        begin
            interval_next = cfg_wr_data;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            aprlm_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    case (in_data.operation)
                        aprlm_pkg::OP_SAMPLE:
                        begin
                            if (!in_data.sample_invalid)
                            begin
                                if (smp_mag > peak_hold_reg)
                                begin
                                    peak_hold_next = smp_mag;
                                end
                                if (valid_count_reg != aprlm_pkg::COUNT_MAX)
                                begin
                                    valid_count_next = valid_count_reg + 1'b1;
                                end
                                mul_a_next = WB'(smp_mag);
                                mul_p_next = {{WB{1'b0}}, WB'(smp_mag)};
                                cnt_next   = '0;
                                state_next = aprlm_pkg::S_SQ_MUL;
                            end
                        end
                        aprlm_pkg::OP_TICK:
                        begin
                            if (elapsed_reg != '1)
                            begin
                                elapsed_next = elapsed_reg + 1'b1;
                            end
                        end
                        aprlm_pkg::OP_FRAME_END:
                        begin
                            if (elapsed_reg >= interval_reg)
                            begin
                                res_next.peak_magnitude  = aprlm_pkg::MAG_BITS'(peak_hold_reg);
                                res_next.peak_silent     = (peak_hold_reg == '0);
                                res_next.counted_samples = valid_count_reg;
                                cnt_next  = '0;
                                rem_next  = '0;
                                root_next = '0;
                                work_next = square_sum_reg;
                                if (valid_count_reg == '0)
                                begin
                                    state_next = aprlm_pkg::S_CLAMP;
                                end
                                else
                                begin
                                    state_next = aprlm_pkg::S_DIV;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            aprlm_pkg::S_SQ_MUL:
            begin
                mul_p_next = mul_step;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == aprlm_pkg::MUL_LAST)
                begin
                    state_next = aprlm_pkg::S_SQ_ACC;
                end
            end
            aprlm_pkg::S_SQ_ACC:
            begin
                square_sum_next = sum_add[aprlm_pkg::SUM_BITS] ? '1
                                                               : sum_add[aprlm_pkg::SUM_BITS-1:0];
                state_next = aprlm_pkg::S_IDLE;
            end
            aprlm_pkg::S_DIV:
            begin
                rem_next  = div_ge ? 34'(div_diff) : 34'(div_sh);
                work_next = {work_reg[aprlm_pkg::SUM_BITS-2:0], div_ge};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == aprlm_pkg::DIV_LAST)
                begin
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = aprlm_pkg::S_SQRT;
                end
            end
            aprlm_pkg::S_SQRT:
            begin
                rem_next  = sq_ge ? sq_diff : sq_rem;
                root_next = {root_reg[WB-2:0], sq_ge};
                work_next = {work_reg[aprlm_pkg::SUM_BITS-3:0], 2'b00};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == aprlm_pkg::SQRT_LAST)
                begin
                    state_next = aprlm_pkg::S_CLAMP;
                end
            end
            aprlm_pkg::S_CLAMP:
            begin
                rms_next                = rms_clamp;
                res_next.rms_magnitude  = aprlm_pkg::MAG_BITS'(rms_clamp);
                res_next.rms_silent     = (rms_clamp == '0);
                sel_next                = 1'b0;
                state_next              = aprlm_pkg::S_LVL_START;
            end
            aprlm_pkg::S_LVL_START:
            begin
                if (lvl_a == '0)
                begin
                    db_next    = aprlm_pkg::SILENT_DB;
                    state_next = aprlm_pkg::S_LVL_END;
                end
                else
                begin
                    mul_a_next = WB'(lvl_a);
                    n_next     = 5'(WB - 1);
                    state_next = aprlm_pkg::S_NORM;
                end
            end
            aprlm_pkg::S_NORM:
            begin
                if (mul_a_reg[WB-1])
                begin
                    mul_a_next = {1'b0, mul_a_reg[WB-1:1]};
                    mul_p_next = {{WB{1'b0}}, 1'b0, mul_a_reg[WB-1:1]};
                    cnt_next   = '0;
                    step_next  = '0;
                    state_next = aprlm_pkg::S_LOG_MUL;
                end
                else
                begin
                    mul_a_next = {mul_a_reg[WB-2:0], 1'b0};
                    n_next     = n_reg - 1'b1;
                end
            end
            aprlm_pkg::S_LOG_MUL:
            begin
                mul_p_next = mul_step;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == aprlm_pkg::MUL_LAST)
                begin
                    state_next = aprlm_pkg::S_LOG_STEP;
                end
            end
            aprlm_pkg::S_LOG_STEP:
            begin
                frac_next  = {frac_reg[aprlm_pkg::LOG_FRAC_BITS-2:0], log_y[WB-1]};
                mul_a_next = log_y_adj;
                mul_p_next = {{WB{1'b0}}, log_y_adj};
                cnt_next   = '0;
                if (step_reg == aprlm_pkg::LOG_LAST)
                begin
                    state_next = aprlm_pkg::S_DB_PREP;
                end
                else
                begin
                    step_next  = step_reg + 1'b1;
                    state_next = aprlm_pkg::S_LOG_MUL;
                end
            end
            aprlm_pkg::S_DB_PREP:
            begin
                if ((n_reg > 5'(SB - 1)) || (LB'(frac_reg) > m_base))
                begin
                    db_next    = '0;
                    state_next = aprlm_pkg::S_LVL_END;
                end
                else
                begin
                    mul_a_next = WB'(m_val);
                    mul_p_next = {{WB{1'b0}}, aprlm_pkg::DB_SCALE_K};
                    cnt_next   = '0;
                    state_next = aprlm_pkg::S_DB_MUL;
                end
            end
            aprlm_pkg::S_DB_MUL:
            begin
                mul_p_next = mul_step;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == aprlm_pkg::MUL_LAST)
                begin
                    state_next = aprlm_pkg::S_DB_DONE;
                end
            end
            aprlm_pkg::S_DB_DONE:
            begin
                db_next    = db_neg;
                state_next = aprlm_pkg::S_LVL_END;
            end
            aprlm_pkg::S_LVL_END:
            begin
                if (!sel_reg)
                begin
                    res_next.peak_dbfs_tenths = db_reg;
                    sel_next   = 1'b1;
                    state_next = aprlm_pkg::S_LVL_START;
                end
                else
                begin
                    res_next.rms_dbfs_tenths = db_reg;
                    peak_hold_next   = '0;
                    square_sum_next  = '0;
                    valid_count_next = '0;
                    elapsed_next     = '0;
                    state_next       = aprlm_pkg::S_OUT;
                end
            end
            aprlm_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_data_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = aprlm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = aprlm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= aprlm_pkg::S_IDLE;
            interval_reg    <= aprlm_pkg::INTERVAL_RESET;
            peak_hold_reg   <= '0;
            square_sum_reg  <= '0;
            valid_count_reg <= '0;
            elapsed_reg     <= '0;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
            n_reg           <= '0;
            step_reg        <= '0;
            sel_reg         <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            interval_reg    <= interval_next;
            peak_hold_reg   <= peak_hold_next;
            square_sum_reg  <= square_sum_next;
            valid_count_reg <= valid_count_next;
            elapsed_reg     <= elapsed_next;
            out_valid_reg   <= out_valid_next;
            cnt_reg         <= cnt_next;
            n_reg           <= n_next;
            step_reg        <= step_next;
            sel_reg         <= sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        res_reg      <= res_next;
        mul_a_reg    <= mul_a_next;
        mul_p_reg    <= mul_p_next;
        work_reg     <= work_next;
        rem_reg      <= rem_next;
        root_reg     <= root_next;
        rms_reg      <= rms_next;
        frac_reg     <= frac_next;
        db_reg       <= db_next;
    end

endmodule

@@ bench/testbench.sv @@
// Self-checking testbench for audio_peak_rms_level_meter_unit with a built-in level predictor.
// It runs directed and random sample, tick and frame-end streams with random idle cycles.
// Depends on aprlm_pkg and the RTL of the level meter only.
module testbench;

    localparam logic [1:0] OP_UNUSED       = 2'd3;
    localparam int         SETTLE_CYCLES   = 100;
    localparam int         PHASES          = 10;
    localparam int         ITEMS_PER_PHASE = 100;
    localparam int         CYCLE_LIMIT     = 10_000_000;

    class level_scoreboard;
        logic [aprlm_pkg::TICK_BITS-1:0]  interval_len;
        logic [aprlm_pkg::MAG_BITS-1:0]   loudest;
        logic [aprlm_pkg::SUM_BITS-1:0]   energy_sum;
        logic [aprlm_pkg::COUNT_BITS-1:0] sample_tally;
        logic [aprlm_pkg::TICK_BITS-1:0]  tick_tally;
        aprlm_pkg::meter_out_t            pending_reports[$];
        int                               mismatches;
        int                               transfers_in;
        int                               reports_checked;

        function new();
            interval_len    = aprlm_pkg::INTERVAL_RESET;
            loudest         = '0;
            energy_sum      = '0;
            sample_tally    = '0;
            tick_tally      = '0;
            mismatches      = 0;
            transfers_in    = 0;
            reports_checked = 0;
        endfunction

        function logic [aprlm_pkg::SUM_BITS-1:0] int_sqrt(logic [aprlm_pkg::SUM_BITS-1:0] v);
            logic [aprlm_pkg::SUM_BITS-1:0] root;
            logic [aprlm_pkg::SUM_BITS-1:0] probe;
            root  = '0;
            probe = aprlm_pkg::SUM_BITS'(1) << 62;
            while (probe > v)
                probe >>= 2;
            while (probe != 0)
            begin
                if (v >= root + probe)
                begin
                    v    = v - (root + probe);
                    root = (root >> 1) + probe;
                end
                else
                    root >>= 1;
                probe >>= 2;
            end
            return root;
        endfunction

        // Level below full scale from a serial log2, scaled to tenths of a decibel.
        function logic [aprlm_pkg::DB_BITS-1:0] dbfs_tenths_of(
            logic [aprlm_pkg::SUM_BITS-1:0] a);
            int unsigned                    msb;
            logic [aprlm_pkg::SUM_BITS-1:0] y;
            logic [aprlm_pkg::SUM_BITS-1:0] frac;
            logic [aprlm_pkg::SUM_BITS-1:0] below;
            logic [aprlm_pkg::SUM_BITS-1:0] mag;
            msb  = 0;
            frac = '0;
            if (a == 0)
                return aprlm_pkg::SILENT_DB;
            while (msb < 63 && (a >> (msb + 1)) != 0)
                msb++;
            y = (msb <= 30) ? (a << (30 - msb)) : (a >> (msb - 30));
            for (int i = 0; i < aprlm_pkg::LOG_FRAC_BITS; i++)
            begin
                y = (y * y) >> 30;
                if (y >= (aprlm_pkg::SUM_BITS'(1) << 31))
                begin
                    y >>= 1;
                    frac[aprlm_pkg::LOG_FRAC_BITS-1-i] = 1'b1;
                end
            end
            if (msb > aprlm_pkg::SAMPLE_BITS - 1)
                return '0;
            below = aprlm_pkg::SUM_BITS'(aprlm_pkg::SAMPLE_BITS - 1 - msb)
                    << aprlm_pkg::LOG_FRAC_BITS;
            if (frac > below)
                return '0;
            below = below - frac;
            mag = (below * aprlm_pkg::SUM_BITS'(aprlm_pkg::DB_SCALE_K)
                   + (aprlm_pkg::SUM_BITS'(1) << 47)) >> 48;
            if (mag > 2048)
                mag = 2048;
            return aprlm_pkg::DB_BITS'(-mag);
        endfunction

        function void note_input(aprlm_pkg::meter_in_t item);
            logic [aprlm_pkg::SAMPLE_BITS-1:0] raw;
            logic [aprlm_pkg::SUM_BITS-1:0]    mag;
            logic [aprlm_pkg::SUM_BITS-1:0]    square;
            logic [aprlm_pkg::SUM_BITS-1:0]    root;
            aprlm_pkg::meter_out_t             report;
            transfers_in++;
            case (item.operation)
                aprlm_pkg::OP_SAMPLE:
                    if (!item.sample_invalid)
                    begin
                        raw = item.sample;
                        mag = raw[aprlm_pkg::SAMPLE_BITS-1] ?
                              (aprlm_pkg::SUM_BITS'(1) << aprlm_pkg::SAMPLE_BITS)
                              - aprlm_pkg::SUM_BITS'(raw) : aprlm_pkg::SUM_BITS'(raw);
                        if (mag > aprlm_pkg::SUM_BITS'(loudest))
                            loudest = aprlm_pkg::MAG_BITS'(mag);
                        square = mag * mag;
                        if (energy_sum > ~square)
                            energy_sum = '1;
                        else
                            energy_sum = energy_sum + square;
                        if (sample_tally != aprlm_pkg::COUNT_MAX)
                            sample_tally++;
                    end
                aprlm_pkg::OP_TICK:
                    if (tick_tally != '1)
                        tick_tally++;
                aprlm_pkg::OP_FRAME_END:
                    if (tick_tally >= interval_len)
                    begin
                        root = (sample_tally != 0) ?
                               int_sqrt(energy_sum / aprlm_pkg::SUM_BITS'(sample_tally))
                               : aprlm_pkg::SUM_BITS'(0);
                        if (root > aprlm_pkg::SUM_BITS'(aprlm_pkg::FULL_SCALE))
                            root = aprlm_pkg::SUM_BITS'(aprlm_pkg::FULL_SCALE);
                        report.peak_magnitude   = loudest;
                        report.rms_magnitude    = aprlm_pkg::MAG_BITS'(root);
                        report.peak_dbfs_tenths =
                            dbfs_tenths_of(aprlm_pkg::SUM_BITS'(loudest));
                        report.rms_dbfs_tenths  = dbfs_tenths_of(root);
                        report.peak_silent      = (loudest == 0);
                        report.rms_silent       = (root == 0);
                        report.counted_samples  = sample_tally;
                        pending_reports.push_back(report);
                        loudest      = '0;
                        energy_sum   = '0;
                        sample_tally = '0;
                        tick_tally   = '0;
                    end
                default: ;
            endcase
        endfunction

        task report_mismatch(string what);
            $display("MISMATCH at %0t: %s", $time, what);
            mismatches++;
        endtask

        task check_field(string name, longint got, longint want);
            if (got != want)
                report_mismatch($sformatf("%s is %0d, expected %0d in report %0d",
                                          name, got, want, reports_checked));
        endtask

        task check_report(aprlm_pkg::meter_out_t got);
            aprlm_pkg::meter_out_t want;
            reports_checked++;
            if (pending_reports.size() == 0)
            begin
                report_mismatch("level report arrived with none expected");
                return;
            end
            want = pending_reports.pop_front();
            check_field("peak_magnitude", got.peak_magnitude, want.peak_magnitude);
            check_field("rms_magnitude", got.rms_magnitude, want.rms_magnitude);
            check_field("peak_dbfs_tenths", got.peak_dbfs_tenths, want.peak_dbfs_tenths);
            check_field("rms_dbfs_tenths", got.rms_dbfs_tenths, want.rms_dbfs_tenths);
            check_field("peak_silent", got.peak_silent, want.peak_silent);
            check_field("rms_silent", got.rms_silent, want.rms_silent);
            check_field("counted_samples", got.counted_samples, want.counted_samples);
        endtask
    endclass

    logic                            clk;
    logic                            rst_n       = 1'b0;
    logic                            in_valid    = 1'b0;
    logic                            in_ready;
    aprlm_pkg::meter_in_t            in_data     = '0;
    logic                            out_valid;
    logic                            out_ready   = 1'b0;
    aprlm_pkg::meter_out_t           out_data;
    logic                            cfg_wr_en   = 1'b0;
    logic [aprlm_pkg::TICK_BITS-1:0] cfg_wr_data = '0;

    level_scoreboard board;
    bit              idling = 1'b1;
    int              stall_left = 0;
    int              cycle_count = 0;
    int              interval_writes = 0;

    audio_peak_rms_level_meter_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("audio_peak_rms_level_meter_unit test failed");
        $finish;
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                board.check_report(out_data);
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic send_item(input aprlm_pkg::meter_in_t item);
        if (idling && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_input(item);
    endtask

    task automatic send_fields(input logic [1:0] op, input int value, input logic invalid);
        aprlm_pkg::meter_in_t item;
        item.operation      = op;
        item.sample         = aprlm_pkg::SAMPLE_BITS'(value);
        item.sample_invalid = invalid;
        send_item(item);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_interval(input logic [aprlm_pkg::TICK_BITS-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        board.interval_len = value;
        interval_writes++;
    endtask

    function automatic aprlm_pkg::meter_in_t random_item(input int amp_bits);
        aprlm_pkg::meter_in_t item;
        int                   wide;
        int                   pick;
        pick = $urandom_range(0, 99);
        item.operation = (pick < 58) ? aprlm_pkg::OP_SAMPLE :
                         (pick < 82) ? aprlm_pkg::OP_TICK :
                         (pick < 97) ? aprlm_pkg::OP_FRAME_END : OP_UNUSED;
        wide = $urandom;
        wide = (wide <<< (32 - amp_bits)) >>> (32 - amp_bits);
        case ($urandom_range(0, 15))
            0:       item.sample = {1'b1, {(aprlm_pkg::SAMPLE_BITS-1){1'b0}}};
            1:       item.sample = {1'b0, {(aprlm_pkg::SAMPLE_BITS-1){1'b1}}};
            2:       item.sample = aprlm_pkg::SAMPLE_BITS'($urandom);
            default: item.sample = aprlm_pkg::SAMPLE_BITS'(wide);
        endcase
        item.sample_invalid = ($urandom_range(0, 9) == 0);
        return item;
    endfunction

    initial
    begin
        aprlm_pkg::meter_in_t            item;
        int                              amp;
        int                              counted;
        logic [aprlm_pkg::TICK_BITS-1:0] next_interval;

        board = new;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fields(aprlm_pkg::OP_SAMPLE, 8388607, 1'b0);
        send_fields(aprlm_pkg::OP_SAMPLE, -8388608, 1'b1);
        send_fields(OP_UNUSED, int'($urandom), 1'b1);
        send_fields(aprlm_pkg::OP_TICK, 0, 1'b0);
        send_fields(aprlm_pkg::OP_FRAME_END, 0, 1'b0);
        write_interval('0);
        send_fields(aprlm_pkg::OP_FRAME_END, 0, 1'b0);
        send_fields(aprlm_pkg::OP_FRAME_END, 0, 1'b0);
        send_fields(aprlm_pkg::OP_SAMPLE, -8388608, 1'b0);
        send_fields(aprlm_pkg::OP_SAMPLE, 0, 1'b0);
        send_fields(aprlm_pkg::OP_SAMPLE, 1, 1'b0);
        send_fields(aprlm_pkg::OP_SAMPLE, -1, 1'b0);
        send_fields(aprlm_pkg::OP_FRAME_END, 0, 1'b0);
        send_fields(aprlm_pkg::OP_SAMPLE, 0, 1'b0);
        send_fields(aprlm_pkg::OP_SAMPLE, 0, 1'b0);
        send_fields(aprlm_pkg::OP_FRAME_END, 0, 1'b0);
        send_fields(aprlm_pkg::OP_SAMPLE, 1, 1'b0);
        send_fields(aprlm_pkg::OP_FRAME_END, 0, 1'b0);
        write_interval(aprlm_pkg::TICK_BITS'(1));
        send_fields(aprlm_pkg::OP_FRAME_END, 0, 1'b0);
        send_fields(aprlm_pkg::OP_TICK, 0, 1'b0);
        send_fields(aprlm_pkg::OP_SAMPLE, -2, 1'b0);
        send_fields(aprlm_pkg::OP_FRAME_END, 0, 1'b0);
        write_interval('1);
        send_fields(aprlm_pkg::OP_TICK, 0, 1'b0);
        send_fields(aprlm_pkg::OP_SAMPLE, 4660, 1'b0);
        send_fields(aprlm_pkg::OP_FRAME_END, 0, 1'b0);

        amp = aprlm_pkg::SAMPLE_BITS;
        for (int ph = 0; ph < PHASES; ph++)
        begin
            next_interval = (ph == 4) ? aprlm_pkg::INTERVAL_RESET
                                      : aprlm_pkg::TICK_BITS'($urandom_range(0, 8));
            write_interval(next_interval);
            idling  = (ph < PHASES - 2) && ($urandom_range(0, 3) != 0);
            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                item = random_item(amp);
                send_item(item);
                if (item.operation != OP_UNUSED &&
                    !(item.operation == aprlm_pkg::OP_SAMPLE && item.sample_invalid))
                    counted++;
                if (item.operation == aprlm_pkg::OP_FRAME_END)
                    amp = $urandom_range(1, aprlm_pkg::SAMPLE_BITS);
            end
        end

        wait_drained();
        $display("Run covered %0d input transfers and %0d level reports",
                 board.transfers_in, board.reports_checked);
        $display("over %0d interval settings.", interval_writes);
        if (board.mismatches == 0 && board.pending_reports.size() == 0)
            $display("audio_peak_rms_level_meter_unit test passed");
        else
            $display("audio_peak_rms_level_meter_unit test failed");
        $finish;
    end
endmodule

@@ audio_peak_rms_level_meter_unit.f @@
rtl/aprlm_pkg.sv
rtl/audio_peak_rms_level_meter_unit.sv
bench/testbench.sv
